/* hw/rtl/lgts_pkg.sv */
// -----------------------------------------------------------------------------
// LDA Gibbs token sampler package
// Payload types, fixed arithmetic widths and register codes shared by the
// sampler modules.
// -----------------------------------------------------------------------------
`default_nettype none

package lgts_pkg;

	// Count store widths
	localparam int WC_W = 24;
	localparam int TT_W = 32;
	localparam int DC_W = 16;

	// Fixed point datapath widths
	localparam int FAC_W = 24;   // word factor, Q8.16, saturating
	localparam int NUM_W = 41;   // word count in Q.16 plus beta
	localparam int DEN_W = 49;   // topic total in Q.16 plus vocab times beta
	localparam int DOCF_W = 33;  // doc count in Q.16 plus alpha
	localparam int WGT_W = 41;   // one topic weight
	localparam int PRM_W = 24;   // alpha and beta
	localparam int VOC_W = 13;
	localparam int TOP_W = 7;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BETA   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VOCAB  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TOPICS = 2'd3;

	localparam logic [PRM_W-1:0] ALPHA_RST  = 24'd6554;
	localparam logic [PRM_W-1:0] BETA_RST   = 24'd6554;
	localparam logic [VOC_W-1:0] VOCAB_RST  = 13'd4096;
	localparam logic [TOP_W-1:0] TOPICS_RST = 7'd64;

	// Item actions
	localparam logic ACT_ASSIGN   = 1'b0;
	localparam logic ACT_RESAMPLE = 1'b1;

	typedef struct packed {
		logic        action;
		logic [11:0] word;
		logic [9:0]  doc;
		logic [5:0]  current_topic;
		logic [15:0] random_fraction;
	} item_t;

	typedef struct packed {
		logic [5:0] drawn_topic;
		logic       count_underflow;
	} result_t;

endpackage

`default_nettype wire

/* hw/rtl/lda_gibbs_token_sampler.sv */
// -----------------------------------------------------------------------------
// LDA Gibbs token sampler
// Collapsed Gibbs sampling of one token topic over word-topic, topic total
// and doc-topic count stores, with a shared divider under a sequencer.
// -----------------------------------------------------------------------------
//  channel   direction  signals
//  item      in         item_valid, item_ready, item
//  result    out        result_valid, result_ready, result
//  cfg       in         cfg_valid, cfg_ready, cfg_index, cfg_data
//
//  An assign item adds the token to the count stores and then sets its result.
//  A resample item first takes the token out of the counts, then works out a
//  weight per topic in use, waiting on the bit-serial divider for each (it
//  ends early when the denominator is zero or the factor saturates), then
//  walks the topics in the draw and adds the token under the drawn topic.
//  After reset a clearing pass zeroes the count stores; no item is taken
//  during it.
//  A finished result waits in an output register; the next item is taken
//  while it waits, and the block holds its last step until the result moves.
//  Registers are written only while the block is clearing or idle.
// -----------------------------------------------------------------------------
`default_nettype none

module lda_gibbs_token_sampler #(
	parameter int MAX_TOPICS = 64,
	parameter int VOCAB_SIZE = 4096,
	parameter int MAX_DOCS   = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           item_valid,
	output logic                                item_ready,
	input  wire lgts_pkg::item_t                item,
	output logic                                result_valid,
	input  wire logic                           result_ready,
	output lgts_pkg::result_t                   result,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [lgts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lgts_pkg::PRM_W-1:0]     cfg_data
);

	localparam int WT_DEPTH = VOCAB_SIZE * MAX_TOPICS;
	localparam int DT_DEPTH = MAX_DOCS * MAX_TOPICS;
	localparam int WT_AW    = $clog2(WT_DEPTH);
	localparam int DT_AW    = $clog2(DT_DEPTH);
	localparam int TB       = $clog2(MAX_TOPICS);
	localparam int TCW      = $clog2(MAX_TOPICS + 1);
	localparam int CW       = (TCW > 7) ? TCW : 7;
	localparam int CLRN     = (WT_DEPTH > DT_DEPTH) ? WT_DEPTH : DT_DEPTH;
	localparam int CLW      = $clog2(CLRN);
	localparam int TOTW     = lgts_pkg::WGT_W + TB;

	localparam logic [3:0] ST_CLR    = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_RED    = 4'd2;
	localparam logic [3:0] ST_BASE   = 4'd3;
	localparam logic [3:0] ST_UPD_RD = 4'd4;
	localparam logic [3:0] ST_UPD_WR = 4'd5;
	localparam logic [3:0] ST_W_RD   = 4'd6;
	localparam logic [3:0] ST_W_SET  = 4'd7;
	localparam logic [3:0] ST_W_DIV  = 4'd8;
	localparam logic [3:0] ST_W_MUL1 = 4'd9;
	localparam logic [3:0] ST_W_MUL2 = 4'd10;
	localparam logic [3:0] ST_T1     = 4'd11;
	localparam logic [3:0] ST_T2     = 4'd12;
	localparam logic [3:0] ST_S_RD   = 4'd13;
	localparam logic [3:0] ST_S_CMP  = 4'd14;
	localparam logic [3:0] ST_FIN    = 4'd15;

	logic [3:0] state_q;
	logic [CLW-1:0] clr_q;

	// Configuration registers
	logic [lgts_pkg::PRM_W-1:0] alpha_q;
	logic [lgts_pkg::PRM_W-1:0] beta_q;
	logic [lgts_pkg::VOC_W-1:0] vocab_q;
	logic [lgts_pkg::TOP_W-1:0] topics_q;

	// Item context
	logic        action_q;
	logic [11:0] word_q;
	logic [9:0]  doc_q;
	logic [5:0]  ctopic_q;
	logic [15:0] rnd_q;
	logic [WT_AW-1:0] wbase_q;
	logic [DT_AW-1:0] dbase_q;
	logic [40:0]      vb_q;
	logic [TCW-1:0]   tcount_q;
	logic [TB-1:0]    upd_topic_q;
	logic             upd_inc_q;
	logic             under_q;
	logic [TCW-1:0]   k_q;

	// Weight datapath
	logic [lgts_pkg::NUM_W-1:0]  num_n;
	logic [lgts_pkg::DEN_W-1:0]  den_n;
	logic [lgts_pkg::DOCF_W-1:0] docf_q;
	logic [lgts_pkg::FAC_W-1:0]  fac_q;
	logic [39:0]                 plo_q;
	logic [TOTW-1:0]             total_q;
	logic [31:0]                 tlo_q;
	logic [TOTW-1:0]             target_q;
	logic [TOTW-1:0]             cum_q;

	logic result_valid_q;
	lgts_pkg::result_t result_q;

	// Memory ports
	logic [TB-1:0]             rd_topic;
	logic                      mem_re;
	logic                      wt_we;
	logic                      tt_we;
	logic                      dt_we;
	logic [WT_AW-1:0]          wt_addr;
	logic [WT_AW-1:0]          wt_waddr;
	logic [DT_AW-1:0]          dt_addr;
	logic [DT_AW-1:0]          dt_waddr;
	logic [TB-1:0]             tt_waddr;
	logic [lgts_pkg::WC_W-1:0] wt_rdata;
	logic [lgts_pkg::TT_W-1:0] tt_rdata;
	logic [lgts_pkg::DC_W-1:0] dt_rdata;
	logic [lgts_pkg::WC_W-1:0] wt_wdata;
	logic [lgts_pkg::TT_W-1:0] tt_wdata;
	logic [lgts_pkg::DC_W-1:0] dt_wdata;
	logic                      wg_we;
	logic [lgts_pkg::WGT_W-1:0] wg_wdata;
	logic [lgts_pkg::WGT_W-1:0] wg_rdata;

	// Clamped register views and update values
	logic [CW-1:0]             tp_ext;
	logic [CW-1:0]             tc_c;
	logic [CW-1:0]             ct_ext;
	logic [16:0]               v_ext;
	logic [16:0]               vc_c;
	logic [lgts_pkg::WC_W-1:0] wc_n;
	logic [lgts_pkg::TT_W-1:0] tt_n;
	logic [lgts_pkg::DC_W-1:0] dc_n;
	logic                      dec_under;
	logic [TCW-1:0]            k_nxt;
	logic                      k_last;
	logic [TOTW-1:0]           cum_n;
	logic [lgts_pkg::WGT_W-1:0] weight;
	logic [TB+5:0]             topic_out;

	logic div_start;
	logic div_done;
	logic [lgts_pkg::FAC_W-1:0] div_quo;

	assign tp_ext = CW'(topics_q);
	assign tc_c   = (tp_ext == '0) ? CW'(1) :
		((tp_ext > CW'(MAX_TOPICS)) ? CW'(MAX_TOPICS) : tp_ext);
	assign ct_ext = CW'(ctopic_q);
	assign v_ext  = 17'(vocab_q);
	assign vc_c   = (v_ext == '0) ? 17'd1 :
		((v_ext > 17'(VOCAB_SIZE)) ? 17'(VOCAB_SIZE) : v_ext);

	assign k_nxt  = k_q + 1'b1;
	assign k_last = (k_nxt == tcount_q);
	assign cum_n  = cum_q + TOTW'(wg_rdata);
	assign weight = lgts_pkg::WGT_W'(fac_q * docf_q[32:16]) +
		lgts_pkg::WGT_W'(plo_q[39:16]);

	// Divider operands come straight from the read data of this topic.
	assign num_n = lgts_pkg::NUM_W'({wt_rdata, 16'h0000}) +
		lgts_pkg::NUM_W'(beta_q);
	assign den_n = lgts_pkg::DEN_W'({tt_rdata, 16'h0000}) +
		lgts_pkg::DEN_W'(vb_q);

	assign rd_topic = (state_q == ST_UPD_RD || state_q == ST_UPD_WR) ?
		upd_topic_q : k_q[TB-1:0];
	assign mem_re  = (state_q == ST_UPD_RD) || (state_q == ST_W_RD);
	assign wt_addr = wbase_q + WT_AW'(rd_topic);
	assign dt_addr = dbase_q + DT_AW'(rd_topic);

	// Saturating count updates
	always_comb begin
		dec_under = 1'b0;
		if (upd_inc_q) begin
			wc_n = (wt_rdata != '1) ? wt_rdata + 1'b1 : wt_rdata;
			tt_n = (tt_rdata != '1) ? tt_rdata + 1'b1 : tt_rdata;
			dc_n = (dt_rdata != '1) ? dt_rdata + 1'b1 : dt_rdata;
		end else begin
			wc_n = (wt_rdata != '0) ? wt_rdata - 1'b1 : wt_rdata;
			tt_n = (tt_rdata != '0) ? tt_rdata - 1'b1 : tt_rdata;
			dc_n = (dt_rdata != '0) ? dt_rdata - 1'b1 : dt_rdata;
			dec_under = (wt_rdata == '0) || (tt_rdata == '0) || (dt_rdata == '0);
		end
	end

	always_comb begin
		if (state_q == ST_CLR) begin
			wt_we    = ({1'b0, clr_q} < (CLW + 1)'(WT_DEPTH));
			tt_we    = ({1'b0, clr_q} < (CLW + 1)'(MAX_TOPICS));
			dt_we    = ({1'b0, clr_q} < (CLW + 1)'(DT_DEPTH));
			wt_waddr = WT_AW'(clr_q);
			dt_waddr = DT_AW'(clr_q);
			tt_waddr = TB'(clr_q);
			wt_wdata = '0;
			tt_wdata = '0;
			dt_wdata = '0;
		end else begin
			wt_we    = (state_q == ST_UPD_WR);
			tt_we    = (state_q == ST_UPD_WR);
			dt_we    = (state_q == ST_UPD_WR);
			wt_waddr = wt_addr;
			dt_waddr = dt_addr;
			tt_waddr = rd_topic;
			wt_wdata = wc_n;
			tt_wdata = tt_n;
			dt_wdata = dc_n;
		end
	end

	assign wg_we     = (state_q == ST_W_MUL2);
	assign wg_wdata  = weight;
	assign div_start = (state_q == ST_W_SET);

	lgts_ram #(.WIDTH(lgts_pkg::WC_W), .DEPTH(WT_DEPTH)) u_wt_ram (
		.clk   (clk),
		.we    (wt_we),
		.waddr (wt_waddr),
		.wdata (wt_wdata),
		.re    (mem_re),
		.raddr (wt_addr),
		.rdata (wt_rdata)
	);

	lgts_ram #(.WIDTH(lgts_pkg::TT_W), .DEPTH(MAX_TOPICS)) u_tt_ram (
		.clk   (clk),
		.we    (tt_we),
		.waddr (tt_waddr),
		.wdata (tt_wdata),
		.re    (mem_re),
		.raddr (rd_topic),
		.rdata (tt_rdata)
	);

	lgts_ram #(.WIDTH(lgts_pkg::DC_W), .DEPTH(DT_DEPTH)) u_dt_ram (
		.clk   (clk),
		.we    (dt_we),
		.waddr (dt_waddr),
		.wdata (dt_wdata),
		.re    (mem_re),
		.raddr (dt_addr),
		.rdata (dt_rdata)
	);

	lgts_ram #(.WIDTH(lgts_pkg::WGT_W), .DEPTH(MAX_TOPICS)) u_wg_ram (
		.clk   (clk),
		.we    (wg_we),
		.waddr (k_q[TB-1:0]),
		.wdata (wg_wdata),
		.re    (state_q == ST_S_RD),
		.raddr (k_q[TB-1:0]),
		.rdata (wg_rdata)
	);

	lgts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_n),
		.den    (den_n),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Configuration registers
	assign cfg_ready = (state_q == ST_CLR) || (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= lgts_pkg::ALPHA_RST;
			beta_q   <= lgts_pkg::BETA_RST;
			vocab_q  <= lgts_pkg::VOCAB_RST;
			topics_q <= lgts_pkg::TOPICS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lgts_pkg::CFG_ALPHA:  alpha_q  <= cfg_data;
				lgts_pkg::CFG_BETA:   beta_q   <= cfg_data;
				lgts_pkg::CFG_VOCAB:  vocab_q  <= cfg_data[lgts_pkg::VOC_W-1:0];
				lgts_pkg::CFG_TOPICS: topics_q <= cfg_data[lgts_pkg::TOP_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLR;
			clr_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLW'(CLRN - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_valid && item_ready) begin
						state_q <= ST_RED;
					end
				end
				ST_RED: begin
					if ({5'b0, word_q} < 17'(VOCAB_SIZE) && {7'b0, doc_q} < 17'(MAX_DOCS)) begin
						state_q <= ST_BASE;
					end
				end
				ST_BASE:   state_q <= ST_UPD_RD;
				ST_UPD_RD: state_q <= ST_UPD_WR;
				ST_UPD_WR: state_q <= upd_inc_q ? ST_FIN : ST_W_RD;
				ST_W_RD:   state_q <= ST_W_SET;
				ST_W_SET:  state_q <= ST_W_DIV;
				ST_W_DIV: begin
					if (div_done) begin
						state_q <= ST_W_MUL1;
					end
				end
				ST_W_MUL1: state_q <= ST_W_MUL2;
				ST_W_MUL2: state_q <= k_last ? ST_T1 : ST_W_RD;
				ST_T1:     state_q <= ST_T2;
				ST_T2:     state_q <= ST_S_RD;
				ST_S_RD:   state_q <= ST_S_CMP;
				ST_S_CMP: begin
					if (cum_n >= target_q || k_last) begin
						state_q <= ST_UPD_RD;
					end else begin
						state_q <= ST_S_RD;
					end
				end
				ST_FIN: begin
					if (!result_valid_q || result_ready) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				action_q <= item.action;
				word_q   <= item.word;
				doc_q    <= item.doc;
				ctopic_q <= item.current_topic;
				rnd_q    <= item.random_fraction;
				under_q  <= 1'b0;
			end
			ST_RED: begin
				// Indexes beyond the store depth wrap by repeated subtraction.
				if ({5'b0, word_q} >= 17'(VOCAB_SIZE)) begin
					word_q <= 12'({5'b0, word_q} - 17'(VOCAB_SIZE));
				end else if ({7'b0, doc_q} >= 17'(MAX_DOCS)) begin
					doc_q <= 10'({7'b0, doc_q} - 17'(MAX_DOCS));
				end
			end
			ST_BASE: begin
				wbase_q     <= WT_AW'(word_q) * WT_AW'(MAX_TOPICS);
				dbase_q     <= DT_AW'(doc_q) * DT_AW'(MAX_TOPICS);
				vb_q        <= 41'(vc_c) * 41'(beta_q);
				tcount_q    <= TCW'(tc_c);
				upd_topic_q <= (ct_ext >= tc_c) ? TB'(tc_c - 1'b1) : TB'(ct_ext);
				upd_inc_q   <= (action_q == lgts_pkg::ACT_ASSIGN);
			end
			ST_UPD_WR: begin
				if (!upd_inc_q) begin
					under_q <= dec_under;
					upd_inc_q <= 1'b1;
				end
				k_q     <= '0;
				total_q <= '0;
			end
			ST_W_SET: begin
				docf_q <= lgts_pkg::DOCF_W'({dt_rdata, 16'h0000}) +
					lgts_pkg::DOCF_W'(alpha_q);
			end
			ST_W_DIV: begin
				fac_q <= div_quo;
			end
			ST_W_MUL1: begin
				plo_q <= 40'(fac_q * docf_q[15:0]);
			end
			ST_W_MUL2: begin
				total_q <= total_q + TOTW'(weight);
				k_q     <= k_nxt;
			end
			ST_T1: begin
				tlo_q <= 32'(rnd_q * total_q[15:0]);
			end
			ST_T2: begin
				// Target is the ceiling of random_fraction times total over 2^16.
				target_q <= TOTW'(rnd_q * total_q[TOTW-1:16]) +
					TOTW'((33'(tlo_q) + 33'h0FFFF) >> 16);
				k_q   <= '0;
				cum_q <= '0;
			end
			ST_S_CMP: begin
				cum_q <= cum_n;
				if (cum_n >= target_q) begin
					upd_topic_q <= k_q[TB-1:0];
				end else if (k_last) begin
					upd_topic_q <= '0;
				end else begin
					k_q <= k_nxt;
				end
			end
			ST_FIN: begin
				if (!result_valid_q || result_ready) begin
					result_q.drawn_topic     <= topic_out[5:0];
					result_q.count_underflow <= under_q;
				end
			end
			default: ;
		endcase
	end

	assign topic_out    = (TB + 6)'(upd_topic_q);
	assign item_ready   = (state_q == ST_IDLE) && !cfg_valid;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// An accepted item keeps the block busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> !item_ready)
		else $error("sampler took an item while busy");

	// The divider only reports completion while the sequencer waits for it.
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_W_DIV))
		else $error("divider finished outside its wait step");

	// The running sum of the walk never decreases.
	a_cum_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_S_CMP) |=> (cum_q >= $past(cum_q)))
		else $error("cumulative weight decreased");

endmodule

`default_nettype wire

/* hw/rtl/lgts_ram.sv */
// -----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
`default_nettype none

module lgts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/lgts_div.sv */
// -----------------------------------------------------------------------------
// Word factor divider
// Restoring divider giving one quotient bit per cycle of the saturating
// Q8.16 factor (num << 16) / den.
// -----------------------------------------------------------------------------
`default_nettype none

module lgts_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [lgts_pkg::NUM_W-1:0] num,
	input  wire logic [lgts_pkg::DEN_W-1:0] den,
	output logic                            done,
	output logic      [lgts_pkg::FAC_W-1:0] quo
);

	logic                       busy_q;
	logic                       done_q;
	logic [4:0]                 cnt_q;
	logic [lgts_pkg::DEN_W-1:0] rem_q;
	logic [lgts_pkg::DEN_W-1:0] den_q;
	logic [lgts_pkg::FAC_W-1:0] lo_q;
	logic [lgts_pkg::FAC_W-1:0] quo_q;
	logic [lgts_pkg::DEN_W:0]   trial;
	logic                       fits;

	assign trial = {rem_q, lo_q[lgts_pkg::FAC_W-1]};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den == '0) begin
					done_q <= 1'b1;
				end else if (lgts_pkg::DEN_W'(num >> 8) >= den) begin
					// The quotient would not fit in 24 bits.
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= 5'(lgts_pkg::FAC_W - 1);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= lgts_pkg::DEN_W'(num >> 8);
			lo_q  <= {num[7:0], 16'h0000};
			if (den == '0) begin
				quo_q <= '0;
			end else begin
				quo_q <= '1;
			end
		end else if (busy_q) begin
			lo_q <= {lo_q[lgts_pkg::FAC_W-2:0], 1'b0};
			if (fits) begin
				rem_q <= lgts_pkg::DEN_W'(trial - {1'b0, den_q});
				quo_q <= {quo_q[lgts_pkg::FAC_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[lgts_pkg::DEN_W-1:0];
				quo_q <= {quo_q[lgts_pkg::FAC_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// LDA Gibbs token sampler testbench
// Drives assign and resample items under random gaps and result stalls,
// predicts results with an in-bench model of the count stores and the fixed
// point topic draw or a given expectation, and walks several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

	localparam int N_TOP = 64;
	localparam int N_VOC = 4096;
	localparam int N_DOC = 1024;

	typedef struct {
		lgts_pkg::item_t   it;
		bit                chk;
		lgts_pkg::result_t exp;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	lgts_pkg::item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	lgts_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [lgts_pkg::CFG_IDX_W-1:0] cfg_index = lgts_pkg::CFG_ALPHA;
	logic [lgts_pkg::PRM_W-1:0] cfg_data = '0;

	// Model copy of the count stores and registers
	bit [lgts_pkg::WC_W-1:0] word_cnt[N_VOC*N_TOP];
	bit [lgts_pkg::TT_W-1:0] topic_tot[N_TOP];
	bit [lgts_pkg::DC_W-1:0] doc_cnt[N_DOC*N_TOP];
	bit [lgts_pkg::PRM_W-1:0] m_alpha = lgts_pkg::ALPHA_RST;
	bit [lgts_pkg::PRM_W-1:0] m_beta = lgts_pkg::BETA_RST;
	bit [lgts_pkg::VOC_W-1:0] m_vocab = lgts_pkg::VOCAB_RST;
	bit [lgts_pkg::TOP_W-1:0] m_topics = lgts_pkg::TOPICS_RST;

	lgts_pkg::result_t topic_queue[$];
	row_t dir_rows[$];
	int errors = 0;
	bit calm = 1'b0;
	int ready_hold = 0;

	// Tokens placed so far, so resamples can name their real topic
	bit [11:0] tok_word[64];
	bit [9:0] tok_doc[64];
	bit [5:0] tok_topic[64];
	int n_tok = 0;

	lda_gibbs_token_sampler dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#150000000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	function automatic void bump_counts(int wi, int di, int t);
		if (word_cnt[wi] != {lgts_pkg::WC_W{1'b1}}) word_cnt[wi]++;
		if (topic_tot[t] != {lgts_pkg::TT_W{1'b1}}) topic_tot[t]++;
		if (doc_cnt[di] != {lgts_pkg::DC_W{1'b1}}) doc_cnt[di]++;
	endfunction

	function automatic lgts_pkg::result_t sample_topic(lgts_pkg::item_t it);
		int tc, vc, topic, wb, db, chosen;
		bit under;
		longint unsigned num, den, f, a, total, cum, target, r;
		longint unsigned wgt[N_TOP];
		lgts_pkg::result_t res;
		tc = int'(m_topics);
		vc = int'(m_vocab);
		if (tc < 1) tc = 1;
		if (tc > N_TOP) tc = N_TOP;
		if (vc < 1) vc = 1;
		if (vc > N_VOC) vc = N_VOC;
		topic = int'(it.current_topic);
		if (topic >= tc) topic = tc - 1;
		wb = (int'(it.word) % N_VOC) * N_TOP;
		db = (int'(it.doc) % N_DOC) * N_TOP;
		under = 1'b0;
		chosen = topic;
		if (it.action == lgts_pkg::ACT_RESAMPLE) begin
			if (word_cnt[wb+topic] == 0) under = 1'b1; else word_cnt[wb+topic]--;
			if (topic_tot[topic] == 0) under = 1'b1; else topic_tot[topic]--;
			if (doc_cnt[db+topic] == 0) under = 1'b1; else doc_cnt[db+topic]--;
			total = 0;
			for (int k = 0; k < tc; k++) begin
				num = (64'(word_cnt[wb+k]) << 16) + 64'(m_beta);
				den = (64'(topic_tot[k]) << 16) + 64'(vc) * 64'(m_beta);
				f = (den != 0) ? (num << 16) / den : 64'd0;
				if (f > 64'hFFFFFF) f = 64'hFFFFFF;
				a = (64'(doc_cnt[db+k]) << 16) + 64'(m_alpha);
				wgt[k] = (f * a) >> 16;
				total += wgt[k];
			end
			r = 64'(it.random_fraction);
			target = r * (total >> 16) + ((r * (total & 64'hFFFF) + 64'hFFFF) >> 16);
			chosen = 0;
			cum = 0;
			for (int k = 0; k < tc; k++) begin
				cum += wgt[k];
				if (cum >= target) begin
					chosen = k;
					break;
				end
			end
		end
		bump_counts(wb + chosen, db + chosen, chosen);
		res.drawn_topic = 6'(chosen);
		res.count_underflow = under;
		return res;
	endfunction

	// Holds the write channel valid; the caller drops it after its last write.
	task automatic write_reg(logic [lgts_pkg::CFG_IDX_W-1:0] idx,
			logic [lgts_pkg::PRM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			lgts_pkg::CFG_ALPHA:  m_alpha = val;
			lgts_pkg::CFG_BETA:   m_beta = val;
			lgts_pkg::CFG_VOCAB:  m_vocab = val[lgts_pkg::VOC_W-1:0];
			lgts_pkg::CFG_TOPICS: m_topics = val[lgts_pkg::TOP_W-1:0];
			default: ;
		endcase
	endtask

	// Registers change only once the block has drained.
	task automatic set_phase(logic [lgts_pkg::PRM_W-1:0] al, logic [lgts_pkg::PRM_W-1:0] be,
			logic [lgts_pkg::PRM_W-1:0] vo, logic [lgts_pkg::PRM_W-1:0] to);
		item_valid <= 1'b0;
		while (topic_queue.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		write_reg(lgts_pkg::CFG_ALPHA, al);
		write_reg(lgts_pkg::CFG_BETA, be);
		write_reg(lgts_pkg::CFG_VOCAB, vo);
		write_reg(lgts_pkg::CFG_TOPICS, to);
		cfg_valid <= 1'b0;
	endtask

	// Drives one item, and returns once it is accepted with its result queued.
	task automatic send_item(lgts_pkg::item_t it, bit chk, lgts_pkg::result_t exp_res);
		lgts_pkg::result_t pred;
		int g;
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		pred = sample_topic(it);
		topic_queue.push_back(chk ? exp_res : pred);
		g = calm ? 0 : gap_len();
		if (g > 0) begin
			item_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic lgts_pkg::item_t random_item();
		lgts_pkg::item_t it;
		int p, i;
		p = $urandom_range(0, 99);
		it.random_fraction = 16'($urandom_range(0, 65535));
		if (p < 12 || (p < 70 && n_tok == 0)) begin
			it.action = 1'($urandom_range(0, 1));
			it.word = 12'($urandom_range(0, 4095));
			it.doc = 10'($urandom_range(0, 1023));
			it.current_topic = 6'($urandom_range(0, 63));
		end else if (p < 70) begin
			i = $urandom_range(0, n_tok - 1);
			it.action = lgts_pkg::ACT_RESAMPLE;
			it.word = tok_word[i];
			it.doc = tok_doc[i];
			it.current_topic = tok_topic[i];
		end else begin
			it.action = lgts_pkg::ACT_ASSIGN;
			it.word = ($urandom_range(0, 9) == 0) ? 12'hFFF : 12'($urandom_range(0, 7));
			it.doc = ($urandom_range(0, 9) == 0) ? 10'h3FF : 10'($urandom_range(0, 3));
			it.current_topic = 6'($urandom_range(0, 63));
		end
		return it;
	endfunction

	task automatic run_random(int count);
		lgts_pkg::item_t it;
		lgts_pkg::result_t pred;
		int slot;
		for (int n = 0; n < count; n++) begin
			it = random_item();
			if (n == count / 2) begin
				item_valid <= 1'b0;
				do @(posedge clk); while (topic_queue.size() != 0);
			end
			calm = ((n / 40) % 4 == 3);
			send_item(it, 1'b0, '0);
			pred = topic_queue[$];
			// Track well-formed tokens with the topic they now hold.
			slot = -1;
			for (int i = 0; i < n_tok; i++)
				if (tok_word[i] == it.word && tok_doc[i] == it.doc) slot = i;
			if (slot < 0 && it.action == lgts_pkg::ACT_ASSIGN && n_tok < 64) begin
				slot = n_tok;
				n_tok++;
			end
			if (slot >= 0) begin
				tok_word[slot] = it.word;
				tok_doc[slot] = it.doc;
				tok_topic[slot] = pred.drawn_topic;
			end
		end
		calm = 1'b0;
	endtask

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
			if (!calm && $urandom_range(0, 3) == 0) ready_hold = gap_len();
		end
	end

	always @(posedge clk) begin
		lgts_pkg::result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (topic_queue.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result topic=%0d uf=%0b",
					result.drawn_topic, result.count_underflow);
			end else begin
				want = topic_queue.pop_front();
				if (want.drawn_topic !== result.drawn_topic ||
						want.count_underflow !== result.count_underflow) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected topic=%0d uf=%0b, got topic=%0d uf=%0b",
							want.drawn_topic, want.count_underflow,
							result.drawn_topic, result.count_underflow);
				end
			end
		end
	end

	initial begin
		dir_rows.push_back('{'{lgts_pkg::ACT_RESAMPLE, 12'd0, 10'd0, 6'd0, 16'd0}, 1'b1,
			'{6'd0, 1'b1}});
		dir_rows.push_back('{'{lgts_pkg::ACT_ASSIGN, 12'd0, 10'd0, 6'd63, 16'd0}, 1'b1,
			'{6'd63, 1'b0}});
		dir_rows.push_back('{'{lgts_pkg::ACT_ASSIGN, 12'hFFF, 10'h3FF, 6'd0, 16'hFFFF}, 1'b1,
			'{6'd0, 1'b0}});
		dir_rows.push_back('{'{lgts_pkg::ACT_RESAMPLE, 12'd0, 10'd0, 6'd63, 16'hFFFF}, 1'b0,
			'0});
		dir_rows.push_back('{'{lgts_pkg::ACT_RESAMPLE, 12'hFFF, 10'h3FF, 6'd0, 16'd0}, 1'b0,
			'0});
		dir_rows.push_back('{'{lgts_pkg::ACT_RESAMPLE, 12'hFFF, 10'h3FF, 6'd10, 16'h8000},
			1'b0, '0});
		dir_rows.push_back('{'{lgts_pkg::ACT_ASSIGN, 12'd5, 10'd2, 6'd20, 16'd0}, 1'b1,
			'{6'd20, 1'b0}});
		dir_rows.push_back('{'{lgts_pkg::ACT_RESAMPLE, 12'd5, 10'd2, 6'd20, 16'd1}, 1'b0,
			'0});
		dir_rows.push_back('{'{lgts_pkg::ACT_ASSIGN, 12'hAAA, 10'h155, 6'h2A, 16'h5555}, 1'b1,
			'{6'h2A, 1'b0}});
		dir_rows.push_back('{'{lgts_pkg::ACT_ASSIGN, 12'h555, 10'h2AA, 6'h15, 16'hAAAA}, 1'b1,
			'{6'h15, 1'b0}});
		dir_rows.push_back('{'{lgts_pkg::ACT_RESAMPLE, 12'hAAA, 10'h155, 6'h2A, 16'hAAAA},
			1'b0, '0});
		dir_rows.push_back('{'{lgts_pkg::ACT_RESAMPLE, 12'h555, 10'h2AA, 6'h15, 16'h5555},
			1'b0, '0});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].chk, dir_rows[i].exp);

		// A zero beta gives empty topics a zero denominator.
		set_phase(24'd0, 24'd0, 24'd1, 24'd4);
		run_random(150);
		// Out-of-range vocabulary and topic counts clamp.
		set_phase(24'hFFFFFF, 24'hFFFFFF, 24'd8191, 24'd0);
		run_random(100);
		set_phase(24'd6554, 24'd100, 24'd4096, 24'd127);
		run_random(60);
		set_phase(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'h3FFFF)),
			24'd0, 24'd16);
		run_random(200);
		set_phase(24'($urandom_range(0, 24'h3FFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
			24'($urandom_range(1, 4096)), 24'd2);
		run_random(190);

		item_valid <= 1'b0;
		while (topic_queue.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0 && topic_queue.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
